// ----- hdl/srt_pkg.sv -----
`timescale 1ns / 1ps

package srt_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_DELTA_TEMP      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_USB_LOW_MV      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_USB_HIGH_MV     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_BATTERY_MV  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HEARTBEAT_TICKS = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CONFIRM_COUNT   = 3'd5;

  localparam logic [11:0] DELTA_TEMP_RESET      = 12'd150;
  localparam logic [12:0] USB_LOW_MV_RESET      = 13'd3270;
  localparam logic [12:0] USB_HIGH_MV_RESET     = 13'd3340;
  localparam logic [12:0] LOW_BATTERY_MV_RESET  = 13'd3000;
  localparam logic [15:0] HEARTBEAT_TICKS_RESET = 16'd330;
  localparam logic [3:0]  CONFIRM_COUNT_RESET   = 4'd3;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_KEY    = 2'd1;
  localparam logic [1:0] CMD_DONE   = 2'd2;

  localparam logic [1:0] CAUSE_RESET = 2'd0;
  localparam logic [1:0] CAUSE_TEMP  = 2'd1;
  localparam logic [1:0] CAUSE_TIMER = 2'd2;
  localparam logic [1:0] CAUSE_KEY   = 2'd3;

  localparam logic [4:0] PERIOD_USB     = 5'd2;
  localparam logic [4:0] PERIOD_BATTERY = 5'd18;
  localparam logic [4:0] PERIOD_LOW     = 5'd28;

  typedef struct packed {
    logic [11:0] delta_temp;
    logic [12:0] usb_low_mv;
    logic [12:0] usb_high_mv;
    logic [12:0] low_battery_mv;
    logic [15:0] heartbeat_ticks;
    logic [3:0]  confirm_count;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [12:0] vbat_mv;
    logic [14:0] temperature;
    logic        send_ok;
  } event_t;

  typedef struct packed {
    logic       report_pending;
    logic [1:0] report_cause;
    logic [4:0] sample_period_s;
    logic       battery_low;
  } report_t;

  function automatic logic [3:0] bump4(input logic [3:0] v);
    return (v == 4'hF) ? v : v + 4'd1;
  endfunction

  function automatic logic [15:0] bump16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

// ----- hdl/srt_event_if.sv -----
`timescale 1ns / 1ps

interface srt_event_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [12:0] vbat_mv;
  logic signed [14:0] temperature;
  logic        send_ok;

  modport source(output valid, command, vbat_mv, temperature, send_ok, input ready);
  modport sink(input valid, command, vbat_mv, temperature, send_ok, output ready);
endinterface

// ----- hdl/srt_report_if.sv -----
`timescale 1ns / 1ps

interface srt_report_if;
  logic       valid;
  logic       ready;
  logic       report_pending;
  logic [1:0] report_cause;
  logic [4:0] sample_period_s;
  logic       battery_low;

  modport source(output valid, report_pending, report_cause, sample_period_s, battery_low,
                 input ready);
  modport sink(input valid, report_pending, report_cause, sample_period_s, battery_low,
               output ready);
endinterface

// ----- hdl/srt_state.sv -----
`timescale 1ns / 1ps

module srt_state (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  srt_pkg::event_t item,
  input  srt_pkg::cfg_t   cfg,
  output srt_pkg::report_t result
);

  logic signed [14:0] sent_temp, sent_temp_next;
  logic signed [14:0] last_temp, last_temp_next;
  logic [3:0]  usb_count, usb_count_next;
  logic [3:0]  low_count, low_count_next;
  logic [3:0]  drift_count, drift_count_next;
  logic [15:0] hb_count, hb_count_next;
  logic        low_flag, low_flag_next;
  logic [4:0]  period, period_next;
  logic        pending, pending_next;
  logic [1:0]  cause, cause_next;

  logic signed [15:0] diff;
  logic [15:0] diff_abs;
  logic [14:0] mag;
  logic [15:0] mag_twice;
  logic        in_usb_window;

  always_comb begin
    diff      = 16'($signed(item.temperature)) - 16'(sent_temp);
    diff_abs  = diff[15] ? 16'(-diff) : 16'(diff);
    mag       = diff_abs[14:0];
    mag_twice = {mag, 1'b0};
    in_usb_window = (item.vbat_mv >= cfg.usb_low_mv) && (item.vbat_mv < cfg.usb_high_mv);
  end

  always_comb begin
    sent_temp_next   = sent_temp;
    last_temp_next   = last_temp;
    usb_count_next   = usb_count;
    low_count_next   = low_count;
    drift_count_next = drift_count;
    hb_count_next    = hb_count;
    low_flag_next    = low_flag;
    period_next      = period;
    pending_next     = pending;
    cause_next       = cause;
    case (item.command)
      srt_pkg::CMD_SAMPLE: begin
        if (in_usb_window) begin
          usb_count_next = srt_pkg::bump4(usb_count);
          if (usb_count_next >= cfg.confirm_count) begin
            period_next    = srt_pkg::PERIOD_USB;
            usb_count_next = 4'd0;
          end
          low_count_next = 4'd0;
          low_flag_next  = 1'b0;
        end else if (item.vbat_mv < cfg.low_battery_mv) begin
          low_count_next = srt_pkg::bump4(low_count);
          if (low_count_next >= cfg.confirm_count) begin
            period_next    = srt_pkg::PERIOD_LOW;
            low_flag_next  = 1'b1;
            low_count_next = 4'd0;
          end
          usb_count_next = 4'd0;
        end else if (item.vbat_mv >= cfg.usb_high_mv) begin
          usb_count_next = 4'd0;
          period_next    = srt_pkg::PERIOD_BATTERY;
          low_count_next = 4'd0;
          low_flag_next  = 1'b0;
        end

        hb_count_next = srt_pkg::bump16(hb_count);
        if (hb_count_next >= cfg.heartbeat_ticks) begin
          pending_next  = 1'b1;
          cause_next    = srt_pkg::CAUSE_TIMER;
          hb_count_next = 16'd0;
        end

        last_temp_next = $signed(item.temperature);
        if ({1'b0, mag} >= {4'd0, cfg.delta_temp}) begin
          pending_next     = 1'b1;
          cause_next       = srt_pkg::CAUSE_TEMP;
          drift_count_next = 4'd0;
        end else if (mag_twice >= {4'd0, cfg.delta_temp}) begin
          drift_count_next = srt_pkg::bump4(drift_count);
          if (drift_count_next >= cfg.confirm_count) begin
            pending_next     = 1'b1;
            cause_next       = srt_pkg::CAUSE_TEMP;
            drift_count_next = 4'd0;
          end
        end else begin
          drift_count_next = 4'd0;
        end
      end
      srt_pkg::CMD_KEY: begin
        pending_next = 1'b1;
        cause_next   = srt_pkg::CAUSE_KEY;
      end
      srt_pkg::CMD_DONE: begin
        if (item.send_ok) begin
          sent_temp_next = last_temp;
        end
        pending_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.report_pending  = pending_next;
    result.report_cause    = cause_next;
    result.sample_period_s = period_next;
    result.battery_low     = low_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sent_temp   <= '0;
      last_temp   <= '0;
      usb_count   <= '0;
      low_count   <= '0;
      drift_count <= '0;
      hb_count    <= '0;
      low_flag    <= 1'b0;
      period      <= srt_pkg::PERIOD_BATTERY;
      pending     <= 1'b1;
      cause       <= srt_pkg::CAUSE_RESET;
    end else if (step) begin
      sent_temp   <= sent_temp_next;
      last_temp   <= last_temp_next;
      usb_count   <= usb_count_next;
      low_count   <= low_count_next;
      drift_count <= drift_count_next;
      hb_count    <= hb_count_next;
      low_flag    <= low_flag_next;
      period      <= period_next;
      pending     <= pending_next;
      cause       <= cause_next;
    end
  end

  // A confirmed low supply always comes with the long wake-up period.
  assert property (@(posedge clk) disable iff (rst)
    low_flag |-> period == srt_pkg::PERIOD_LOW)
    else $error("low battery flag set without the low battery period");

  // A successful send moves the reference to the last sampled temperature.
  assert property (@(posedge clk) disable iff (rst)
    step && item.command == srt_pkg::CMD_DONE && item.send_ok |=> sent_temp == $past(last_temp))
    else $error("reference temperature not taken on a successful send");

  // Without a successful send the reference temperature stays where it is.
  assert property (@(posedge clk) disable iff (rst)
    !(step && item.command == srt_pkg::CMD_DONE && item.send_ok) |=> $stable(sent_temp))
    else $error("reference temperature moved without a successful send");

endmodule

// ----- hdl/sensor_report_trigger_unit.sv -----
`timescale 1ns / 1ps

// Report trigger for a battery-powered temperature node. Each event word
// (sample tick, key press or transmit done) yields exactly one report word that
// shows the request flag, its cause, the wake-up period and the low battery flag
// after the event. One event word is taken every clock cycle while reports are
// taken; a word passes an input register and the state update, and its report is
// loaded into the output register when that register is empty or being read,
// and a ready sink takes it. While a report waits at the output, the input
// register can take one more word and then holds off until the report is taken.
module sensor_report_trigger_unit (
  input  logic                             clk,
  input  logic                             rst,
  srt_event_if.sink                        events,
  srt_report_if.source                     reports,
  input  logic                             cfg_we,
  input  logic [srt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [srt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  srt_pkg::cfg_t    cfg;
  srt_pkg::event_t  item;
  srt_pkg::report_t result;
  srt_pkg::report_t report_q;
  logic item_full;
  logic report_valid;
  logic step;
  logic accept;

  assign step   = item_full && (!report_valid || reports.ready);
  assign accept = events.valid && events.ready;
  assign events.ready = !item_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delta_temp      <= srt_pkg::DELTA_TEMP_RESET;
      cfg.usb_low_mv      <= srt_pkg::USB_LOW_MV_RESET;
      cfg.usb_high_mv     <= srt_pkg::USB_HIGH_MV_RESET;
      cfg.low_battery_mv  <= srt_pkg::LOW_BATTERY_MV_RESET;
      cfg.heartbeat_ticks <= srt_pkg::HEARTBEAT_TICKS_RESET;
      cfg.confirm_count   <= srt_pkg::CONFIRM_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        srt_pkg::REG_DELTA_TEMP:      cfg.delta_temp      <= cfg_data[11:0];
        srt_pkg::REG_USB_LOW_MV:      cfg.usb_low_mv      <= cfg_data[12:0];
        srt_pkg::REG_USB_HIGH_MV:     cfg.usb_high_mv     <= cfg_data[12:0];
        srt_pkg::REG_LOW_BATTERY_MV:  cfg.low_battery_mv  <= cfg_data[12:0];
        srt_pkg::REG_HEARTBEAT_TICKS: cfg.heartbeat_ticks <= cfg_data[15:0];
        srt_pkg::REG_CONFIRM_COUNT:   cfg.confirm_count   <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (accept) begin
      item_full <= 1'b1;
    end else if (step) begin
      item_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.command     <= events.command;
      item.vbat_mv     <= events.vbat_mv;
      item.temperature <= events.temperature;
      item.send_ok     <= events.send_ok;
    end
  end

  srt_state u_state (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else if (step) begin
      report_valid <= 1'b1;
    end else if (reports.ready) begin
      report_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      report_q <= result;
    end
  end

  assign reports.valid           = report_valid;
  assign reports.report_pending  = report_q.report_pending;
  assign reports.report_cause    = report_q.report_cause;
  assign reports.sample_period_s = report_q.sample_period_s;
  assign reports.battery_low     = report_q.battery_low;

  // A key press always leaves a pending request with the key cause.
  assert property (@(posedge clk) disable iff (rst)
    step && item.command == srt_pkg::CMD_KEY |=>
      report_q.report_pending && report_q.report_cause == srt_pkg::CAUSE_KEY)
    else $error("key press did not raise a key report");

  // A transmit done always clears the request.
  assert property (@(posedge clk) disable iff (rst)
    step && item.command == srt_pkg::CMD_DONE |=> !report_q.report_pending)
    else $error("transmit done left a request pending");

  // A full input register that cannot advance must hold off new words.
  assert property (@(posedge clk) disable iff (rst)
    item_full && !step |-> !events.ready)
    else $error("input register would be overwritten");

endmodule

// ----- verif/sensor_report_trigger_unit_tb.sv -----
`timescale 1ns / 1ps

module sensor_report_trigger_unit_tb;
  import srt_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RESET_CYCLES = 11;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_OFF_CYCLES = 250;
  localparam int HOLD_OFF_SPACING = 120;
  localparam int QUIET_LIMIT = 3000;
  localparam int NUM_SETTINGS = 6;
  localparam int NUM_PHASES = 8;
  localparam int NUM_ROWS = 24;
  localparam int MAX_REPORTED = 10;

  typedef enum int {
    SUPPLY_USB,
    SUPPLY_LOW,
    SUPPLY_BATTERY,
    SUPPLY_BOUNDARY,
    SUPPLY_ANY
  } supply_kind_t;

  typedef struct packed {
    event_t  w;
    logic    typed;
    report_t rep;
  } script_row_t;

  typedef struct packed {
    int cfg_sel;
    int gap_pct;
    int stall_pct;
    int words;
    bit pressure;
  } phase_t;

  typedef struct {
    logic signed [15:0] sent_temp;
    logic signed [15:0] last_temp;
    logic [3:0]         usb_run;
    logic [3:0]         low_run;
    logic [3:0]         drift_run;
    logic [15:0]        beat_count;
    logic               low_flag;
    logic [4:0]         period;
    logic               pending;
    logic [1:0]         cause;
  } node_state_t;

  localparam cfg_t CFG_SETS [NUM_SETTINGS] = '{
    '{DELTA_TEMP_RESET, USB_LOW_MV_RESET, USB_HIGH_MV_RESET, LOW_BATTERY_MV_RESET,
      HEARTBEAT_TICKS_RESET, CONFIRM_COUNT_RESET},
    '{12'd2, 13'd0, 13'd8191, 13'd0, 16'd1, 4'd1},
    '{12'd4000, 13'd8191, 13'd0, 13'd8191, 16'd65535, 4'd15},
    '{12'd0, 13'd2000, 13'd2600, 13'd1500, 16'd0, 4'd0},
    '{12'd40, 13'd3500, 13'd4200, 13'd3300, 16'd25, 4'd2},
    '{12'd4095, 13'd1000, 13'd1001, 13'd7000, 16'd7, 4'd5}
  };

  localparam phase_t PHASES [NUM_PHASES] = '{
    '{0, 0, 0, 250, 1'b0},
    '{1, 77, 0, 200, 1'b0},
    '{2, 0, 77, 250, 1'b0},
    '{3, 11, 11, 200, 1'b0},
    '{4, 0, 0, 250, 1'b1},
    '{5, 77, 0, 200, 1'b0},
    '{0, 0, 77, 300, 1'b0},
    '{5, 11, 11, 275, 1'b0}
  };

  localparam script_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{'{CMD_UNUSED, 13'h1FFF, 15'h7FFF, 1'b1}, 1'b1,
      '{1'b1, CAUSE_RESET, PERIOD_BATTERY, 1'b0}},
    '{'{CMD_DONE, 13'd0, 15'd0, 1'b0}, 1'b1, '{1'b0, CAUSE_RESET, PERIOD_BATTERY, 1'b0}},
    '{'{CMD_SAMPLE, 13'd3400, 15'd0, 1'b0}, 1'b1,
      '{1'b0, CAUSE_RESET, PERIOD_BATTERY, 1'b0}},
    '{'{CMD_KEY, 13'd0, 15'd0, 1'b0}, 1'b1, '{1'b1, CAUSE_KEY, PERIOD_BATTERY, 1'b0}},
    '{'{CMD_DONE, 13'd0, 15'd0, 1'b1}, 1'b1, '{1'b0, CAUSE_KEY, PERIOD_BATTERY, 1'b0}},
    '{'{CMD_SAMPLE, 13'd8191, 15'd13000, 1'b0}, 1'b1,
      '{1'b1, CAUSE_TEMP, PERIOD_BATTERY, 1'b0}},
    '{'{CMD_DONE, 13'd0, 15'd0, 1'b1}, 1'b1, '{1'b0, CAUSE_TEMP, PERIOD_BATTERY, 1'b0}},
    '{'{CMD_SAMPLE, 13'd0, -15'sd4500, 1'b0}, 1'b1,
      '{1'b1, CAUSE_TEMP, PERIOD_BATTERY, 1'b0}},
    '{'{CMD_SAMPLE, 13'd0, -15'sd4500, 1'b0}, 1'b1,
      '{1'b1, CAUSE_TEMP, PERIOD_BATTERY, 1'b0}},
    '{'{CMD_SAMPLE, 13'd0, -15'sd4500, 1'b0}, 1'b1, '{1'b1, CAUSE_TEMP, PERIOD_LOW, 1'b1}},
    '{'{CMD_DONE, 13'd0, 15'd0, 1'b1}, 1'b1, '{1'b0, CAUSE_TEMP, PERIOD_LOW, 1'b1}},
    '{'{CMD_SAMPLE, 13'd3100, -15'sd4420, 1'b0}, 1'b0, '0},
    '{'{CMD_SAMPLE, 13'd3300, -15'sd4420, 1'b0}, 1'b0, '0},
    '{'{CMD_SAMPLE, 13'd3300, -15'sd4420, 1'b0}, 1'b0, '0},
    '{'{CMD_SAMPLE, 13'd3300, -15'sd4420, 1'b0}, 1'b0, '0},
    '{'{CMD_DONE, 13'd0, 15'd0, 1'b0}, 1'b0, '0},
    '{'{CMD_SAMPLE, 13'd3269, -15'sd4426, 1'b0}, 1'b0, '0},
    '{'{CMD_SAMPLE, 13'd3340, -15'sd4425, 1'b0}, 1'b0, '0},
    '{'{CMD_SAMPLE, 13'd2999, -15'sd4350, 1'b0}, 1'b0, '0},
    '{'{CMD_SAMPLE, 13'd3000, 15'h4000, 1'b0}, 1'b0, '0},
    '{'{CMD_SAMPLE, 13'd3270, 15'd16383, 1'b0}, 1'b0, '0},
    '{'{CMD_KEY, 13'h1FFF, 15'h7FFF, 1'b1}, 1'b0, '0},
    '{'{CMD_DONE, 13'd0, 15'd0, 1'b1}, 1'b0, '0},
    '{'{CMD_SAMPLE, 13'd3339, 15'd0, 1'b0}, 1'b0, '0}
  };

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  srt_event_if  ev ();
  srt_report_if rp ();

  sensor_report_trigger_unit dut (
    .clk       (clk),
    .rst       (rst),
    .events    (ev),
    .reports   (rp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cfg_t         trig_cfg;
  node_state_t  node;
  supply_kind_t supply_mode;
  report_t      expected_reports[$];

  int send_gap_pct;
  int recv_stall_pct;
  int hold_off_id;
  int fail_count;
  int words_sent;
  int reports_seen;
  int temp_requests;
  int beat_requests;
  int usb_periods;
  int low_periods;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void log_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTED) begin
      $display("%s", msg);
    end
  endfunction

  function automatic report_t apply_event(input event_t w);
    int t;
    int d;
    report_t r;
    t = int'($signed(w.temperature));
    case (w.command)
      CMD_SAMPLE: begin
        if (w.vbat_mv >= trig_cfg.usb_low_mv && w.vbat_mv < trig_cfg.usb_high_mv) begin
          node.usb_run = (node.usb_run == 4'hF) ? node.usb_run : node.usb_run + 4'd1;
          if (node.usb_run >= trig_cfg.confirm_count) begin
            node.period = PERIOD_USB;
            node.usb_run = 4'd0;
            usb_periods++;
          end
          node.low_run = 4'd0;
          node.low_flag = 1'b0;
        end else if (w.vbat_mv < trig_cfg.low_battery_mv) begin
          node.low_run = (node.low_run == 4'hF) ? node.low_run : node.low_run + 4'd1;
          if (node.low_run >= trig_cfg.confirm_count) begin
            node.period = PERIOD_LOW;
            node.low_flag = 1'b1;
            node.low_run = 4'd0;
            low_periods++;
          end
          node.usb_run = 4'd0;
        end else if (w.vbat_mv >= trig_cfg.usb_high_mv) begin
          node.usb_run = 4'd0;
          node.period = PERIOD_BATTERY;
          node.low_run = 4'd0;
          node.low_flag = 1'b0;
        end
        node.beat_count = (node.beat_count == 16'hFFFF) ? node.beat_count
                                                        : node.beat_count + 16'd1;
        if (node.beat_count >= trig_cfg.heartbeat_ticks) begin
          node.pending = 1'b1;
          node.cause = CAUSE_TIMER;
          node.beat_count = 16'd0;
          beat_requests++;
        end
        node.last_temp = t[15:0];
        d = t - int'(node.sent_temp);
        if (d < 0) begin
          d = -d;
        end
        if (d >= int'(trig_cfg.delta_temp)) begin
          node.pending = 1'b1;
          node.cause = CAUSE_TEMP;
          node.drift_run = 4'd0;
          temp_requests++;
        end else if (2 * d >= int'(trig_cfg.delta_temp)) begin
          node.drift_run = (node.drift_run == 4'hF) ? node.drift_run : node.drift_run + 4'd1;
          if (node.drift_run >= trig_cfg.confirm_count) begin
            node.pending = 1'b1;
            node.cause = CAUSE_TEMP;
            node.drift_run = 4'd0;
            temp_requests++;
          end
        end else begin
          node.drift_run = 4'd0;
        end
      end
      CMD_KEY: begin
        node.pending = 1'b1;
        node.cause = CAUSE_KEY;
      end
      CMD_DONE: begin
        if (w.send_ok) begin
          node.sent_temp = node.last_temp;
        end
        node.pending = 1'b0;
      end
      default: begin
      end
    endcase
    r.report_pending = node.pending;
    r.report_cause = node.cause;
    r.sample_period_s = node.period;
    r.battery_low = node.low_flag;
    return r;
  endfunction

  // Supply voltages stay in one band for a while so that the confirmation counters
  // can complete, and temperatures are placed around the full and half thresholds
  // measured from the last sent value.
  function automatic event_t random_event();
    event_t w;
    int pick;
    int lo;
    int hi;
    int low;
    int mv;
    int d;
    int half;
    int span;
    int t;
    pick = $urandom_range(99);
    w.command = (pick < 68) ? CMD_SAMPLE : (pick < 76) ? CMD_KEY :
                (pick < 96) ? CMD_DONE : CMD_UNUSED;
    w.send_ok = ($urandom_range(99) < 80);
    if ($urandom_range(99) < 12) begin
      supply_mode = supply_kind_t'($urandom_range(4));
    end
    lo = int'(trig_cfg.usb_low_mv);
    hi = int'(trig_cfg.usb_high_mv);
    low = int'(trig_cfg.low_battery_mv);
    case (supply_mode)
      SUPPLY_USB: mv = (hi > lo) ? int'($urandom_range(hi - 1, lo)) : int'($urandom_range(8191));
      SUPPLY_LOW: mv = (low > 0) ? int'($urandom_range(low - 1, 0)) : int'($urandom_range(8191));
      SUPPLY_BATTERY: mv = int'($urandom_range(8191, hi));
      SUPPLY_BOUNDARY: begin
        case ($urandom_range(4))
          0: mv = lo;
          1: mv = hi - 1;
          2: mv = hi;
          3: mv = low - 1;
          default: mv = low;
        endcase
      end
      default: mv = int'($urandom_range(8191));
    endcase
    w.vbat_mv = mv[12:0];
    d = int'(trig_cfg.delta_temp);
    half = (d + 1) / 2;
    pick = $urandom_range(99);
    if (pick < 10) begin
      t = int'($urandom_range(17500)) - 4500;
    end else if (pick < 14) begin
      t = int'($urandom_range(32767)) - 16384;
    end else begin
      if (pick < 30) begin
        span = d + int'($urandom_range(3));
      end else if (pick < 38) begin
        span = (d > 0) ? d - 1 : 0;
      end else if (pick < 72) begin
        span = (d - 1 > half) ? int'($urandom_range(d - 1, half)) : half;
      end else if (pick < 80) begin
        span = (half > 0) ? half - 1 : 0;
      end else begin
        span = int'($urandom_range(half));
      end
      if ($urandom_range(1) == 1) begin
        span = -span;
      end
      t = int'(node.sent_temp) + span;
      if (t > 16383 || t < -16384) begin
        t = int'(node.sent_temp) - span;
      end
    end
    w.temperature = t[14:0];
    return w;
  endfunction

  task automatic send_word(input event_t w, input logic typed, input report_t typed_rep);
    report_t predicted;
    while ($urandom_range(99) < send_gap_pct) begin
      ev.valid <= 1'b0;
      @(posedge clk);
    end
    ev.valid <= 1'b1;
    ev.command <= w.command;
    ev.vbat_mv <= w.vbat_mv;
    ev.temperature <= w.temperature;
    ev.send_ok <= w.send_ok;
    @(posedge clk);
    while (!ev.ready) begin
      @(posedge clk);
    end
    predicted = apply_event(w);
    expected_reports.push_back(typed ? typed_rep : predicted);
    words_sent++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic write_settings(input cfg_t c);
    write_reg(REG_DELTA_TEMP, {4'd0, c.delta_temp});
    write_reg(REG_USB_LOW_MV, {3'd0, c.usb_low_mv});
    write_reg(REG_USB_HIGH_MV, {3'd0, c.usb_high_mv});
    write_reg(REG_LOW_BATTERY_MV, {3'd0, c.low_battery_mv});
    write_reg(REG_HEARTBEAT_TICKS, c.heartbeat_ticks);
    write_reg(REG_CONFIRM_COUNT, {12'd0, c.confirm_count});
    cfg_we <= 1'b0;
    trig_cfg = c;
  endtask

  task automatic drain();
    while (expected_reports.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : report_sink
    report_t got;
    report_t want;
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rp.valid && rp.ready) begin
        got = {rp.report_pending, rp.report_cause, rp.sample_period_s, rp.battery_low};
        reports_seen++;
        if (expected_reports.size() == 0) begin
          log_failure($sformatf("Report word %0d arrived with nothing expected: %h",
                                reports_seen, got));
        end else begin
          want = expected_reports.pop_front();
          if (got.report_pending !== want.report_pending ||
              got.report_cause !== want.report_cause ||
              got.sample_period_s !== want.sample_period_s ||
              got.battery_low !== want.battery_low) begin
            log_failure($sformatf({"Report word %0d: expected pending %0d cause %0d ",
                                   "period %0d low %0d, got %0d %0d %0d %0d"},
                                  reports_seen, want.report_pending, want.report_cause,
                                  want.sample_period_s, want.battery_low,
                                  got.report_pending, got.report_cause,
                                  got.sample_period_s, got.battery_low));
          end
        end
      end
      if (hold_seen != hold_off_id) begin
        hold_seen = hold_off_id;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rp.ready <= 1'b0;
      end else begin
        rp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((ev.valid && ev.ready) || (rp.valid && rp.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    event_t w;
    int n;
    int hold_mark;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    ev.valid <= 1'b0;
    ev.command <= CMD_SAMPLE;
    ev.vbat_mv <= '0;
    ev.temperature <= '0;
    ev.send_ok <= 1'b0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    hold_off_id = 0;
    fail_count = 0;
    words_sent = 0;
    reports_seen = 0;
    temp_requests = 0;
    beat_requests = 0;
    usb_periods = 0;
    low_periods = 0;
    supply_mode = SUPPLY_BATTERY;
    trig_cfg = CFG_SETS[0];
    node.sent_temp = '0;
    node.last_temp = '0;
    node.usb_run = '0;
    node.low_run = '0;
    node.drift_run = '0;
    node.beat_count = '0;
    node.low_flag = 1'b0;
    node.period = PERIOD_BATTERY;
    node.pending = 1'b1;
    node.cause = CAUSE_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_ROWS; i++) begin
      send_word(DIRECTED_ROWS[i].w, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].rep);
    end
    ev.valid <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_settings(CFG_SETS[PHASES[p].cfg_sel]);
      send_gap_pct = PHASES[p].gap_pct;
      recv_stall_pct = PHASES[p].stall_pct;
      n = 0;
      hold_mark = -1;
      while (n < PHASES[p].words) begin
        // The long receiver hold-off lets the block fill and push back on its input.
        if (PHASES[p].pressure && n % HOLD_OFF_SPACING == 0 && hold_mark != n) begin
          hold_mark = n;
          hold_off_id++;
        end
        w = random_event();
        if (w.command != CMD_UNUSED) begin
          n++;
        end
        send_word(w, 1'b0, '0);
      end
      ev.valid <= 1'b0;
    end
    drain();

    $display("Covered %0d event words in %0d phases over %0d register settings; %0d reports.",
             words_sent, NUM_PHASES, NUM_SETTINGS, reports_seen);
    $display("Temperature requests %0d, heartbeat requests %0d, USB periods %0d, low %0d.",
             temp_requests, beat_requests, usb_periods, low_periods);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
